@@ rtl/circular_queue_engine_macros.svh @@
// ----------------------------------------------------------------------------
// circular_queue_engine assertion macros
// Shared concurrent assertion forms for the queue checker.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_ENGINE_MACROS_SVH
`define CIRCULAR_QUEUE_ENGINE_MACROS_SVH

// expression must hold at every clock edge outside reset
`define CQE_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: check failed");

// antecedent implies consequent in the same cycle
`define CQE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

`endif

@@ rtl/cqe_pkg.sv @@
// ----------------------------------------------------------------------------
// cqe_pkg
// Types and codes shared by the circular queue engine.
// ----------------------------------------------------------------------------
package cqe_pkg;

  localparam int DATA_W = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  localparam logic [FUNC_W-1:0] FN_ENQ    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DEQ    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK_F = 2'd2;
  localparam logic [FUNC_W-1:0] FN_PEEK_R = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] item_value;
  } cqe_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_value;
    logic [OCC_W-1:0]  occupancy;
  } cqe_out_t;

  // control travelling with a transaction along the slot chain
  typedef struct packed {
    logic              valid;
    logic              wr;
    logic              rd;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occ;
  } cqe_ctl_t;

endpackage

@@ rtl/cqe_slot_cell.sv @@
// ----------------------------------------------------------------------------
// cqe_slot_cell
// One queue slot. Stores the word of its own slot index and passes each
// transaction on to the next cell, loading the slot word on a read hit.
// ----------------------------------------------------------------------------
module cqe_slot_cell
  import cqe_pkg::*;
#(
  parameter int IDX_W   = 4,
  parameter int CELL_ID = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  cqe_ctl_t          in_ctl,
  input  logic [IDX_W-1:0]  in_idx,
  input  logic [DATA_W-1:0] in_data,
  output cqe_ctl_t          out_ctl,
  output logic [IDX_W-1:0]  out_idx,
  output logic [DATA_W-1:0] out_data
);

  logic [DATA_W-1:0] slot;
  logic              hit;

  assign hit = in_ctl.valid && (in_idx == IDX_W'(CELL_ID));

  always_ff @(posedge clk) begin
    if (hit && in_ctl.wr) begin
      slot <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
    out_idx <= in_idx;
    if (hit && in_ctl.rd) begin
      out_data <= slot;
    end else begin
      out_data <= in_data;
    end
  end

endmodule

@@ rtl/circular_queue_engine.sv @@
// ----------------------------------------------------------------------------
// circular_queue_engine
// Circular FIFO queue of 32-bit words with a configurable capacity in use.
// ----------------------------------------------------------------------------
// Command channel: a transaction (cmd.func, cmd.item_value) is taken at a
// clock edge with start high and busy low. busy is high only during reset.
// func selects enqueue, dequeue, peek front or peek rear.
// Result channel: result_valid marks one cycle carrying status, read_value
// and occupancy; the receiver cannot stall, so results are never held.
// Config: cfg_wr_en writes cfg_wr_data into the capacity register.
// Head, tail and count are resolved at acceptance; the transaction then
// walks a chain of DEPTH slot cells, one cell per cycle, where the addressed
// cell writes or reads its word.
// result_valid and result are taken from the output of the last slot cell.
// Throughput: one transaction per cycle, results in command order.
// Reset: queue empty, capacity DEPTH capped at 31, chain emptied; slot words stay
// undefined until written.
// ----------------------------------------------------------------------------
module circular_queue_engine
  import cqe_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cqe_in_t          cmd,
  input  logic             cfg_wr_en,
  input  logic [OCC_W-1:0] cfg_wr_data,
  output logic             result_valid,
  output cqe_out_t         result
);

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W   = ((IDX_W > OCC_W) ? IDX_W : OCC_W) + 1;
  localparam int CAP_MAX = (1 << OCC_W) - 1;
  localparam logic [OCC_W-1:0] CAP_RST = OCC_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);

  logic [OCC_W-1:0] capacity;
  logic [OCC_W-1:0] cap_eff;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] tail_next;
  logic [OCC_W-1:0] count;
  logic [OCC_W-1:0] count_next;
  logic             accept;

  cqe_ctl_t          ctl_s  [0:DEPTH];
  logic [IDX_W-1:0]  idx_s  [0:DEPTH];
  logic [DATA_W-1:0] data_s [0:DEPTH];

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] i,
                                               input logic [OCC_W-1:0] c);
    logic [CMP_W-1:0] n;
    n = CMP_W'(i) + CMP_W'(1);
    return (n >= CMP_W'(c)) ? '0 : n[IDX_W-1:0];
  endfunction

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RST;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_comb begin
    if (capacity == '0) begin
      cap_eff = OCC_W'(1);
    end else if (int'(capacity) > DEPTH) begin
      cap_eff = CAP_RST;
    end else begin
      cap_eff = capacity;
    end
  end

  always_comb begin
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    ctl_s[0].valid   = accept;
    ctl_s[0].wr      = 1'b0;
    ctl_s[0].rd      = 1'b0;
    ctl_s[0].status  = ST_OK;
    idx_s[0]         = head;
    data_s[0]        = '0;
    case (cmd.func)
      FN_ENQ: begin
        if (count >= cap_eff) begin
          ctl_s[0].status = ST_FULL;
        end else begin
          if (count == '0) begin
            head_next = '0;
            tail_next = '0;
          end else begin
            tail_next = advance(tail, cap_eff);
          end
          ctl_s[0].wr = 1'b1;
          idx_s[0]    = tail_next;
          data_s[0]   = cmd.item_value;
          count_next  = count + OCC_W'(1);
        end
      end
      default: begin
        if (count == '0) begin
          ctl_s[0].status = ST_EMPTY;
        end else begin
          ctl_s[0].rd = 1'b1;
          case (cmd.func)
            FN_DEQ: begin
              if (count == OCC_W'(1)) begin
                head_next = '0;
                tail_next = '0;
              end else begin
                head_next = advance(head, cap_eff);
              end
              count_next = count - OCC_W'(1);
            end
            FN_PEEK_R: begin
              idx_s[0] = tail;
            end
            default: begin
              idx_s[0] = head;
            end
          endcase
        end
      end
    endcase
    ctl_s[0].occ = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cqe_slot_cell #(
      .IDX_W   (IDX_W),
      .CELL_ID (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_ctl   (ctl_s[g]),
      .in_idx   (idx_s[g]),
      .in_data  (data_s[g]),
      .out_ctl  (ctl_s[g+1]),
      .out_idx  (idx_s[g+1]),
      .out_data (data_s[g+1])
    );
  end

  assign result_valid      = ctl_s[DEPTH].valid;
  assign result.status     = ctl_s[DEPTH].status;
  assign result.read_value = ctl_s[DEPTH].rd ? data_s[DEPTH] : '0;
  assign result.occupancy  = ctl_s[DEPTH].occ;

endmodule

@@ rtl/cqe_checker.sv @@
// ----------------------------------------------------------------------------
// cqe_checker
// Port-level checks on the circular queue engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "circular_queue_engine_macros.svh"

module cqe_checker
  import cqe_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input cqe_in_t          cmd,
  input logic             cfg_wr_en,
  input logic [OCC_W-1:0] cfg_wr_data,
  input logic             result_valid,
  input cqe_out_t         result
);

  `CQE_ASSERT_IMPL(a_status_code, clk, rst, result_valid, (result.status == ST_OK) || (result.status == ST_FULL) || (result.status == ST_EMPTY))
  `CQE_ASSERT_IMPL(a_full_no_data, clk, rst, result_valid && (result.status == ST_FULL), result.read_value == '0)
  `CQE_ASSERT_IMPL(a_empty_clean, clk, rst, result_valid && (result.status == ST_EMPTY), (result.read_value == '0) && (result.occupancy == '0))
  `CQE_ASSERT_IMPL(a_occ_bound, clk, rst, result_valid, int'(result.occupancy) <= DEPTH)
  `CQE_ASSERT_IMPL(a_no_result_after_reset, clk, rst, $past(rst), !result_valid)

endmodule

bind circular_queue_engine cqe_checker #(
  .DEPTH (DEPTH)
) u_cqe_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .cfg_wr_en    (cfg_wr_en),
  .cfg_wr_data  (cfg_wr_data),
  .result_valid (result_valid),
  .result       (result)
);
